// File: hdl/lbfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbfc_pkg
// Shared types, codes and constants of the LED blink and flash controller.
// ----------------------------------------------------------------------------
package lbfc_pkg;

    localparam int NUM_LEDS_DEF = 3;

    // field widths
    localparam int TGT_W    = 4;
    localparam int MODE_W   = 2;
    localparam int CODE_W   = 8;
    localparam int SECS_W   = 4;
    localparam int ON_W     = 4;
    localparam int MS_W     = 10;
    localparam int STEP_W   = 8;
    localparam int TOGGLE_W = 10;
    localparam int FLAG_W   = 3;
    localparam int PIDX_W   = 2;

    // blink divider: 1000 / code
    localparam logic [TOGGLE_W-1:0] BLINK_DIVIDEND    = 10'd1000;
    localparam logic [TOGGLE_W-1:0] BLINK_ZERO_PERIOD = 10'd1023;

    // register reset values
    localparam logic [MS_W-1:0] FLASH_STEP_RST = 10'd100;
    localparam logic [ON_W-1:0] MASTER_ON_RST  = 4'd5;

    // register indexes
    localparam logic REG_FLASH_STEP = 1'b0;
    localparam logic REG_MASTER_ON  = 1'b1;

    // commands
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SET  = 1'b1;

    // modes
    localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ON    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BLINK = 2'd2;
    localparam logic [MODE_W-1:0] MODE_FLASH = 2'd3;

    // targets
    localparam logic [TGT_W-1:0] TGT_RED   = 4'd0;
    localparam logic [TGT_W-1:0] TGT_GREEN = 4'd1;
    localparam logic [TGT_W-1:0] TGT_BLUE  = 4'd2;
    localparam logic [TGT_W-1:0] TGT_RG    = 4'd3;
    localparam logic [TGT_W-1:0] TGT_RB    = 4'd4;
    localparam logic [TGT_W-1:0] TGT_GR    = 4'd5;
    localparam logic [TGT_W-1:0] TGT_GB    = 4'd6;
    localparam logic [TGT_W-1:0] TGT_BR    = 4'd7;
    localparam logic [TGT_W-1:0] TGT_BG    = 4'd8;

    // LED indexes
    localparam logic [PIDX_W-1:0] LED_RED   = 2'd0;
    localparam logic [PIDX_W-1:0] LED_GREEN = 2'd1;
    localparam logic [PIDX_W-1:0] LED_BLUE  = 2'd2;

    // pattern flag bits
    localparam int FLAG_BLINK = 0;
    localparam int FLAG_FLASH = 1;
    localparam int FLAG_PAIR  = 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_DIV,
        S_SET,
        S_OUT
    } t_state;

    function automatic logic [PIDX_W-1:0] pair_master_of(input logic [TGT_W-1:0] tgt);
        logic [PIDX_W-1:0] led;
        case (tgt)
            TGT_RG, TGT_RB: led = LED_RED;
            TGT_GR, TGT_GB: led = LED_GREEN;
            TGT_BR, TGT_BG: led = LED_BLUE;
            default:        led = LED_RED;
        endcase
        return led;
    endfunction

    function automatic logic [PIDX_W-1:0] pair_slave_of(input logic [TGT_W-1:0] tgt);
        logic [PIDX_W-1:0] led;
        case (tgt)
            TGT_GR, TGT_BR: led = LED_RED;
            TGT_RG, TGT_BG: led = LED_GREEN;
            TGT_RB, TGT_GB: led = LED_BLUE;
            default:        led = LED_GREEN;
        endcase
        return led;
    endfunction

endpackage

// File: hdl/lbfc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbfc_div
// Restoring divider for the blink toggle period: 1000 / divisor, one
// quotient bit per cycle through a single shared subtractor.
// ----------------------------------------------------------------------------
module lbfc_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [lbfc_pkg::CODE_W-1:0]      i_divisor,
    output logic                             o_done,
    output logic [lbfc_pkg::TOGGLE_W-1:0]    o_quot
);

    localparam int QW  = lbfc_pkg::TOGGLE_W;
    localparam int DW  = lbfc_pkg::CODE_W;
    localparam int CW  = $clog2(QW);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [DW-1:0] r_rem, n_rem;
    logic [DW-1:0] r_div, n_div;
    logic [QW-1:0] r_q, n_q;

    logic [DW:0]   shifted;
    logic [DW:0]   diff;
    logic          fits;

    assign shifted = {r_rem, r_q[QW-1]};
    assign diff    = shifted - {1'b0, r_div};
    assign fits    = shifted >= {1'b0, r_div};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_div  = r_div;
        n_q    = r_q;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_div  = i_divisor;
            n_q    = lbfc_pkg::BLINK_DIVIDEND;
        end else if (r_busy) begin
            // shift in the next dividend bit, subtract when it fits
            n_rem = fits ? diff[DW-1:0] : shifted[DW-1:0];
            n_q   = {r_q[QW-2:0], fits};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CW'(QW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_div <= n_div;
        r_q   <= n_q;
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// File: hdl/led_blink_flash_controller_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_blink_flash_controller_unit
// Three-LED blink and flash controller with single and paired patterns.
// ----------------------------------------------------------------------------
// Tick: one LED per cycle through the shared counter/compare unit, then the
//   result goes to the output register (state S_OUT).
// Blink set: the serial divider runs in S_DIV before the S_SET update and S_OUT.
// Other set requests: S_SET, then S_OUT. One request is worked on at a time.
// Reset (synchronous, active low) clears all LED state, sets flash step to
//   100 ms, master on steps to 5, pair master red and pair slave green.
module led_blink_flash_controller_unit #(
    parameter int NUM_LEDS = lbfc_pkg::NUM_LEDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [3:0] target, [5:4] requested_mode, [13:6] blink_rate_code,
    // [17:14] flash_seconds, [21:18] flash_on_count, [23:22] zero
    input  logic [23:0] s_tdata,
    // [0] command
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] red_lit, [1] green_lit, [2] blue_lit, [3] accepted, [7:4] zero
    output logic [7:0]  m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LW     = $clog2(NUM_LEDS);
    localparam int MS_W   = lbfc_pkg::MS_W;
    localparam int STEP_W = lbfc_pkg::STEP_W;
    localparam int TOG_W  = lbfc_pkg::TOGGLE_W;
    localparam int ON_W   = lbfc_pkg::ON_W;
    localparam int FLAG_W = lbfc_pkg::FLAG_W;
    localparam int PW     = lbfc_pkg::PIDX_W;
    localparam int TW     = lbfc_pkg::TGT_W;
    localparam int FB     = lbfc_pkg::FLAG_BLINK;
    localparam int FF     = lbfc_pkg::FLAG_FLASH;
    localparam int FP     = lbfc_pkg::FLAG_PAIR;

    // control state
    lbfc_pkg::t_state r_state, n_state;
    logic [LW-1:0]    r_idx, n_idx;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_out_data, n_out_data;
    logic             r_ok, n_ok;

    // registers
    logic [MS_W-1:0]  r_flash_step;
    logic [ON_W-1:0]  r_master_on;

    // captured request
    logic [TW-1:0]                  r_tgt;
    logic [lbfc_pkg::MODE_W-1:0]    r_mode;
    logic [lbfc_pkg::CODE_W-1:0]    r_code;
    logic [lbfc_pkg::SECS_W-1:0]    r_secs;
    logic [ON_W-1:0]                r_on;

    // per-LED state
    logic [NUM_LEDS-1:0] r_lit, n_lit;
    logic [FLAG_W-1:0]   r_flags [NUM_LEDS];
    logic [FLAG_W-1:0]   n_flags [NUM_LEDS];
    logic [MS_W-1:0]     r_ms [NUM_LEDS];
    logic [MS_W-1:0]     n_ms [NUM_LEDS];
    logic [STEP_W-1:0]   r_step [NUM_LEDS];
    logic [STEP_W-1:0]   n_step [NUM_LEDS];
    logic [TOG_W-1:0]    r_toggle [NUM_LEDS];
    logic [TOG_W-1:0]    n_toggle [NUM_LEDS];
    logic [STEP_W-1:0]   r_fper [NUM_LEDS];
    logic [STEP_W-1:0]   n_fper [NUM_LEDS];
    logic [ON_W-1:0]     r_fon [NUM_LEDS];
    logic [ON_W-1:0]     n_fon [NUM_LEDS];
    logic [PW-1:0]       r_pair_master, n_pair_master;
    logic [PW-1:0]       r_pair_slave, n_pair_slave;

    // sequencer outputs
    logic accept;
    logic out_free;
    logic out_load;
    logic div_start;
    logic tick_en;
    logic set_en;

    logic                        div_done;
    logic [TOG_W-1:0]            div_quot;
    logic                        need_div;
    logic [TW-1:0]               in_tgt;
    logic [lbfc_pkg::MODE_W-1:0] in_mode;
    logic [lbfc_pkg::CODE_W-1:0] in_code;

    assign in_tgt   = s_tdata[3:0];
    assign in_mode  = s_tdata[5:4];
    assign in_code  = s_tdata[13:6];
    assign need_div = (s_tuser == lbfc_pkg::CMD_SET) && (in_mode == lbfc_pkg::MODE_BLINK)
                      && (in_code != '0);

    lbfc_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_divisor (in_code),
        .o_done    (div_done),
        .o_quot    (div_quot)
    );

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            lbfc_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == lbfc_pkg::CMD_TICK) begin
                        n_state = lbfc_pkg::S_TICK;
                    end else if (need_div) begin
                        n_state = lbfc_pkg::S_DIV;
                    end else begin
                        n_state = lbfc_pkg::S_SET;
                    end
                end
            end
            lbfc_pkg::S_TICK: begin
                if (r_idx == LW'(NUM_LEDS - 1)) begin
                    n_state = lbfc_pkg::S_OUT;
                end
            end
            lbfc_pkg::S_DIV: begin
                if (div_done) begin
                    n_state = lbfc_pkg::S_SET;
                end
            end
            lbfc_pkg::S_SET: n_state = lbfc_pkg::S_OUT;
            lbfc_pkg::S_OUT: begin
                if (out_free) begin
                    n_state = lbfc_pkg::S_IDLE;
                end
            end
            default: n_state = lbfc_pkg::S_IDLE;
        endcase
    end

    assign out_free = !r_out_valid || m_tready;

    always_comb begin
        s_tready = 1'b0;
        tick_en  = 1'b0;
        set_en   = 1'b0;
        out_load = 1'b0;
        case (r_state)
            lbfc_pkg::S_IDLE: s_tready = 1'b1;
            lbfc_pkg::S_TICK: tick_en  = 1'b1;
            lbfc_pkg::S_DIV:  ;
            lbfc_pkg::S_SET:  set_en   = 1'b1;
            lbfc_pkg::S_OUT:  out_load = out_free;
            default: ;
        endcase
    end

    assign accept    = s_tvalid && s_tready;
    assign div_start = accept && need_div;

    // ---------------- LED datapath ----------------
    // values of the LED under the shared unit
    logic [FLAG_W-1:0] cur_flags;
    logic [MS_W-1:0]   cur_ms_inc;
    logic [MS_W-1:0]   cur_period;
    logic              cur_active;
    logic              cur_hit;
    logic              cur_pair;
    logic              cur_lit;
    logic [STEP_W-1:0] cur_step;
    logic [STEP_W-1:0] cur_step_inc;
    logic [STEP_W-1:0] cur_step_next;
    logic [ON_W:0]     pair_end;
    logic              step_lit_m;
    logic              step_lit_s;

    always_comb begin
        cur_flags     = r_flags[r_idx];
        cur_lit       = r_lit[r_idx];
        cur_step      = r_step[r_idx];
        cur_active    = cur_flags[FB] || cur_flags[FF];
        cur_period    = cur_flags[FB] ? r_toggle[r_idx] : r_flash_step;
        cur_ms_inc    = r_ms[r_idx] + 1'b1;
        cur_hit       = cur_ms_inc >= cur_period;
        cur_pair      = cur_flags[FP] && (int'(r_pair_master) == int'(r_idx))
                        && (int'(r_pair_slave) < NUM_LEDS)
                        && (r_pair_slave != r_pair_master);
        cur_step_inc  = cur_step + 1'b1;
        cur_step_next = (cur_step_inc >= r_fper[r_idx]) ? '0 : cur_step_inc;
        pair_end      = {1'b0, r_master_on} + {1'b0, r_fon[r_idx]};
        if (cur_flags[FB]) begin
            step_lit_m = !cur_lit;
            step_lit_s = cur_lit;
        end else if (cur_pair) begin
            step_lit_m = cur_step < STEP_W'(r_master_on);
            step_lit_s = !step_lit_m && (cur_step < STEP_W'(pair_end));
        end else begin
            step_lit_m = cur_step < STEP_W'(r_fon[r_idx]);
            step_lit_s = 1'b0;
        end
    end

    // set request decode
    logic          tgt_single;
    logic          tgt_pair;
    logic [PW-1:0] led_a;
    logic [PW-1:0] led_b;
    logic          set_ok;
    logic          do_clear_a, do_clear_b, do_end_pair, do_load, do_slave;
    logic          do_lit_off, do_lit_on, do_step_clr, do_pair_flag;
    logic          is_flash;
    logic [TOG_W-1:0]  load_toggle;
    logic [STEP_W-1:0] load_fper;
    logic [ON_W-1:0]   load_fon;

    always_comb begin
        tgt_single   = r_tgt inside {[lbfc_pkg::TGT_RED:lbfc_pkg::TGT_BLUE]};
        tgt_pair     = r_tgt inside {[lbfc_pkg::TGT_RG:lbfc_pkg::TGT_BG]};
        led_a        = tgt_single ? r_tgt[PW-1:0] : lbfc_pkg::pair_master_of(r_tgt);
        led_b        = lbfc_pkg::pair_slave_of(r_tgt);
        is_flash     = r_mode == lbfc_pkg::MODE_FLASH;
        load_toggle  = (r_code == '0) ? lbfc_pkg::BLINK_ZERO_PERIOD : div_quot;
        load_fper    = {r_secs, 3'b000} + {3'b000, r_secs, 1'b0};
        load_fon     = (r_on == '0) ? '0 : r_on - 1'b1;
        set_ok       = 1'b0;
        do_clear_a   = 1'b0;
        do_clear_b   = 1'b0;
        do_end_pair  = 1'b0;
        do_load      = 1'b0;
        do_slave     = 1'b0;
        do_lit_off   = 1'b0;
        do_lit_on    = 1'b0;
        do_step_clr  = 1'b0;
        do_pair_flag = 1'b0;
        if (tgt_single) begin
            set_ok = int'(r_tgt) < NUM_LEDS;
            if (set_ok) begin
                case (r_mode)
                    lbfc_pkg::MODE_OFF: begin
                        if (cur_flags[FP]) begin
                            do_lit_off  = 1'b1;
                            do_step_clr = led_a == r_pair_master;
                        end else begin
                            do_clear_a = 1'b1;
                        end
                    end
                    lbfc_pkg::MODE_ON: do_lit_on = 1'b1;
                    default: begin
                        do_end_pair = cur_flags[FP];
                        do_load     = 1'b1;
                    end
                endcase
            end
        end else if (tgt_pair) begin
            set_ok = (int'(led_a) < NUM_LEDS) && (int'(led_b) < NUM_LEDS)
                     && (r_mode != lbfc_pkg::MODE_ON);
            if (set_ok) begin
                if (r_mode == lbfc_pkg::MODE_OFF) begin
                    do_clear_a = 1'b1;
                    do_clear_b = 1'b1;
                end else begin
                    do_end_pair  = 1'b1;
                    do_slave     = 1'b1;
                    do_load      = 1'b1;
                    do_pair_flag = 1'b1;
                end
            end
        end
    end

    always_comb begin
        n_lit         = r_lit;
        n_flags       = r_flags;
        n_ms          = r_ms;
        n_step        = r_step;
        n_toggle      = r_toggle;
        n_fper        = r_fper;
        n_fon         = r_fon;
        n_pair_master = r_pair_master;
        n_pair_slave  = r_pair_slave;
        n_ok          = r_ok;
        if (accept) begin
            n_ok = 1'b1;
        end
        for (int i = 0; i < NUM_LEDS; i++) begin
            if (tick_en && cur_active && (i == int'(r_idx))) begin
                if (cur_hit) begin
                    n_ms[i]  = '0;
                    n_lit[i] = step_lit_m;
                    if (!cur_flags[FB]) begin
                        n_step[i] = cur_step_next;
                    end
                end else begin
                    n_ms[i] = cur_ms_inc;
                end
            end
            // the pair master drives its slave on each step
            if (tick_en && cur_active && cur_hit && cur_pair
                && (i == int'(r_pair_slave))) begin
                n_lit[i] = step_lit_s;
            end
            if (set_en) begin
                if (do_end_pair && r_flags[i][FP]) begin
                    n_flags[i] = '0;
                end
                if ((do_clear_a && (i == int'(led_a))) || (do_clear_b && (i == int'(led_b)))) begin
                    n_lit[i]    = 1'b0;
                    n_flags[i]  = '0;
                    n_ms[i]     = '0;
                    n_step[i]   = '0;
                    n_toggle[i] = '0;
                    n_fper[i]   = '0;
                    n_fon[i]    = '0;
                end
                if (i == int'(led_a)) begin
                    if (do_lit_off) begin
                        n_lit[i] = 1'b0;
                    end
                    if (do_lit_on) begin
                        n_lit[i] = 1'b1;
                    end
                    if (do_step_clr) begin
                        n_step[i] = '0;
                    end
                end
                if (do_slave && (i == int'(led_b))) begin
                    n_flags[i]     = '0;
                    n_flags[i][FP] = 1'b1;
                    n_lit[i]       = 1'b0;
                end
                if (do_load && (i == int'(led_a))) begin
                    n_lit[i]       = 1'b0;
                    n_ms[i]        = '0;
                    n_step[i]      = '0;
                    n_flags[i]     = '0;
                    n_flags[i][FP] = do_pair_flag;
                    if (is_flash) begin
                        n_fon[i]       = load_fon;
                        n_fper[i]      = load_fper;
                        n_flags[i][FF] = 1'b1;
                    end else begin
                        n_toggle[i]    = load_toggle;
                        n_flags[i][FB] = 1'b1;
                    end
                end
            end
        end
        if (set_en) begin
            n_ok = set_ok;
            if (do_pair_flag) begin
                n_pair_master = led_a;
                n_pair_slave  = led_b;
            end
        end
    end

    // sequencer index: LED under the shared unit, or the LED a request reads
    always_comb begin
        n_idx = r_idx;
        if (accept) begin
            if (s_tuser == lbfc_pkg::CMD_TICK) begin
                n_idx = '0;
            end else if (in_tgt inside {[lbfc_pkg::TGT_RED:lbfc_pkg::TGT_BLUE]}) begin
                n_idx = LW'(in_tgt);
            end else begin
                n_idx = LW'(lbfc_pkg::pair_master_of(in_tgt));
            end
        end else if (tick_en) begin
            n_idx = r_idx + 1'b1;
        end
    end

    // ---------------- result register ----------------
    logic [NUM_LEDS+2:0] lit_ext;

    assign lit_ext = {3'b000, r_lit};

    always_comb begin
        n_out_valid = r_out_valid && !m_tready;
        n_out_data  = r_out_data;
        if (out_load) begin
            n_out_valid = 1'b1;
            n_out_data  = {4'b0000, r_ok, lit_ext[2:0]};
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

    // ---------------- configuration port ----------------
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == lbfc_pkg::REG_MASTER_ON) ? {28'd0, r_master_on}
                                                          : {22'd0, r_flash_step};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flash_step <= lbfc_pkg::FLASH_STEP_RST;
            r_master_on  <= lbfc_pkg::MASTER_ON_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == lbfc_pkg::REG_FLASH_STEP) begin
                r_flash_step <= pwdata[MS_W-1:0];
            end else begin
                r_master_on <= pwdata[ON_W-1:0];
            end
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= lbfc_pkg::S_IDLE;
            r_idx         <= '0;
            r_out_valid   <= 1'b0;
            r_ok          <= 1'b0;
            r_lit         <= '0;
            r_pair_master <= lbfc_pkg::LED_RED;
            r_pair_slave  <= lbfc_pkg::LED_GREEN;
            for (int i = 0; i < NUM_LEDS; i++) begin
                r_flags[i]  <= '0;
                r_ms[i]     <= '0;
                r_step[i]   <= '0;
                r_toggle[i] <= '0;
                r_fper[i]   <= '0;
                r_fon[i]    <= '0;
            end
        end else begin
            r_state       <= n_state;
            r_idx         <= n_idx;
            r_out_valid   <= n_out_valid;
            r_ok          <= n_ok;
            r_lit         <= n_lit;
            r_pair_master <= n_pair_master;
            r_pair_slave  <= n_pair_slave;
            r_flags       <= n_flags;
            r_ms          <= n_ms;
            r_step        <= n_step;
            r_toggle      <= n_toggle;
            r_fper        <= n_fper;
            r_fon         <= n_fon;
        end
        r_out_data <= n_out_data;
        if (accept) begin
            r_tgt  <= in_tgt;
            r_mode <= in_mode;
            r_code <= in_code;
            r_secs <= s_tdata[17:14];
            r_on   <= s_tdata[21:18];
        end
    end

    // ---------------- assertions ----------------
    logic [NUM_LEDS-1:0] pair_owner;

    always_comb begin
        for (int i = 0; i < NUM_LEDS; i++) begin
            pair_owner[i] = r_flags[i][FP] && (r_flags[i][FB] || r_flags[i][FF]);
        end
    end

    a_one_pair_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(pair_owner) <= 1)
        else $error("more than one LED runs a pair pattern");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == lbfc_pkg::S_DIV))
        else $error("divider finished outside the divide state");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (m_tvalid && (r_state == lbfc_pkg::S_IDLE)))
        else $error("result not presented after load");

    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tick_en || set_en) |-> !s_tready)
        else $error("request taken while a request is at work");

endmodule
